// ===== rtl/isfp_pkg.sv =====
// Shared constants and types for the IMU serial frame parser.
package isfp_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] KIND_ACCEL = 8'h51;
	localparam logic [7:0] KIND_RATE  = 8'h52;
	localparam logic [7:0] KIND_ANGLE = 8'h53;
	localparam logic [3:0] FRAME_LEN  = 4'd11;
	localparam logic [3:0] BODY_START = 4'd2;

	localparam logic [1:0] KIND_ACCEL_CODE = KIND_ACCEL[1:0];
	localparam logic [1:0] KIND_RATE_CODE  = KIND_RATE[1:0];
	localparam logic [1:0] KIND_ANGLE_CODE = KIND_ANGLE[1:0];

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_TYPE = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	typedef struct packed {
		logic               good;
		logic [1:0]         kind;
		logic [31:0]        stamp;
		logic signed [15:0] val0;
		logic signed [15:0] val1;
		logic signed [15:0] val2;
		logic signed [15:0] temp;
	} frame_evt_t;

endpackage

// ===== rtl/isfp_framer.sv =====
// Frame hunter and assembler with running additive checksum.
module isfp_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          rx_byte,
	input  logic [31:0]         now_stamp,
	output isfp_pkg::frame_evt_t evt
);
	import isfp_pkg::*;

	logic [1:0]  phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [7:0]  sum_q, sum_d;
	logic [1:0]  kind_q, kind_d;
	logic [31:0] hdr_stamp_q;
	logic        hdr_load;
	logic        pay_wr;
	logic        good_d;
	logic [3:0]  pay_off;
	logic [7:0]  payload_q [8];

	assign pay_off = cnt_q - BODY_START;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		sum_d    = sum_q;
		kind_d   = kind_q;
		hdr_load = 1'b0;
		pay_wr   = 1'b0;
		good_d   = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				cnt_d = '0;
				if (rx_byte == HDR_BYTE) begin
					hdr_load = 1'b1;
					sum_d    = rx_byte;
					cnt_d    = 4'd1;
					phase_d  = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (rx_byte inside {KIND_ACCEL, KIND_RATE, KIND_ANGLE}) begin
					kind_d  = rx_byte[1:0];
					sum_d   = sum_q + rx_byte;
					cnt_d   = BODY_START;
					phase_d = PH_BODY;
				end else begin
					cnt_d   = '0;
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				if (cnt_q < FRAME_LEN - 4'd1) begin
					pay_wr = 1'b1;
					sum_d  = sum_q + rx_byte;
					cnt_d  = cnt_q + 4'd1;
				end else begin
					good_d  = take && (rx_byte == sum_q);
					cnt_d   = '0;
					phase_d = PH_HUNT;
				end
			end
			default: begin
				cnt_d   = '0;
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			cnt_q       <= '0;
			sum_q       <= '0;
			kind_q      <= '0;
			hdr_stamp_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			kind_q  <= kind_d;
			if (hdr_load) begin
				hdr_stamp_q <= now_stamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && pay_wr) begin
			payload_q[pay_off[2:0]] <= rx_byte;
		end
	end

	assign evt.good  = good_d;
	assign evt.kind  = kind_q;
	assign evt.stamp = hdr_stamp_q;
	assign evt.val0  = {payload_q[1], payload_q[0]};
	assign evt.val1  = {payload_q[3], payload_q[2]};
	assign evt.val2  = {payload_q[5], payload_q[4]};
	assign evt.temp  = {payload_q[7], payload_q[6]};

endmodule

// ===== rtl/imu_serial_frame_parser.sv =====
// Top level of the IMU serial frame parser: value store and record output register.
// The parser takes one received byte per clock while in_ready is high, with no gaps
// required between bytes. It hunts for an 11-byte frame (0x55, type 0x51/0x52/0x53,
// eight payload bytes, sum byte) and keeps the latest raw values of each kind. A record
// appears on the output in the cycle after the checksum byte of a good angle frame,
// provided a good acceleration frame has been seen since reset. The output register
// holds one record; in_ready drops only while that record is waiting and out_ready is low.
module imu_serial_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic [31:0]        now_stamp,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        sequence_res,
	output logic [31:0]        record_stamp,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	output logic signed [15:0] rate_x,
	output logic signed [15:0] rate_y,
	output logic signed [15:0] rate_z,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic signed [15:0] temp_raw
);
	import isfp_pkg::*;

	frame_evt_t         evt;
	logic               take;
	logic               emit;
	logic               out_valid_q;
	logic               accel_seen_q;
	logic [31:0]        saved_stamp_q;
	logic [31:0]        rec_cnt_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [15:0] rx_q, ry_q, rz_q;
	logic [31:0]        seq_out_q, stamp_out_q;
	logic signed [15:0] ax_out_q, ay_out_q, az_out_q;
	logic signed [15:0] rx_out_q, ry_out_q, rz_out_q;
	logic signed [15:0] roll_out_q, pitch_out_q, yaw_out_q, temp_out_q;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign emit     = take && evt.good && (evt.kind == KIND_ANGLE_CODE) && accel_seen_q;

	isfp_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.now_stamp (now_stamp),
		.evt       (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_seen_q  <= 1'b0;
			saved_stamp_q <= '0;
			rec_cnt_q     <= '0;
			ax_q <= '0; ay_q <= '0; az_q <= '0;
			rx_q <= '0; ry_q <= '0; rz_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt.good) begin
				case (evt.kind)
					KIND_ACCEL_CODE: begin
						ax_q <= evt.val0; ay_q <= evt.val1; az_q <= evt.val2;
						saved_stamp_q <= evt.stamp;
						accel_seen_q  <= 1'b1;
					end
					KIND_RATE_CODE: begin
						rx_q <= evt.val0; ry_q <= evt.val1; rz_q <= evt.val2;
					end
					default: begin
					end
				endcase
			end
			if (emit) begin
				rec_cnt_q   <= rec_cnt_q + 32'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			seq_out_q   <= rec_cnt_q;
			stamp_out_q <= saved_stamp_q;
			ax_out_q    <= ax_q;
			ay_out_q    <= ay_q;
			az_out_q    <= az_q;
			rx_out_q    <= rx_q;
			ry_out_q    <= ry_q;
			rz_out_q    <= rz_q;
			roll_out_q  <= evt.val0;
			pitch_out_q <= evt.val1;
			yaw_out_q   <= evt.val2;
			temp_out_q  <= evt.temp;
		end
	end

	assign out_valid    = out_valid_q;
	assign sequence_res = seq_out_q;
	assign record_stamp = stamp_out_q;
	assign accel_x      = ax_out_q;
	assign accel_y      = ay_out_q;
	assign accel_z      = az_out_q;
	assign rate_x       = rx_out_q;
	assign rate_y       = ry_out_q;
	assign rate_z       = rz_out_q;
	assign roll_angle   = roll_out_q;
	assign pitch_angle  = pitch_out_q;
	assign yaw_angle    = yaw_out_q;
	assign temp_raw     = temp_out_q;

endmodule

// ===== bench/tb_imu_serial_frame_parser.sv =====
`timescale 1ns / 1ps
// Testbench for the IMU frame parser: directed frames, then random streams checked by a model.
module tb_imu_serial_frame_parser;
	import isfp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_BYTES = 1490;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [31:0]      seq_no;
		logic [31:0]      stamp;
		logic [0:9][15:0] vals;
	} imu_record_t;

	typedef struct packed {
		logic [7:0]       kind_byte;
		logic [0:3][15:0] words;
		logic [7:0]       sum_skew;
		logic [31:0]      hdr_stamp;
		logic             has_typed;
		imu_record_t      typed;
	} frame_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic [31:0]        now_stamp;
	logic               out_valid;
	logic               out_ready;
	logic [31:0]        sequence_res;
	logic [31:0]        record_stamp;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] rate_x;
	logic signed [15:0] rate_y;
	logic signed [15:0] rate_z;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic signed [15:0] temp_raw;

	imu_serial_frame_parser dut (.*);

	logic [1:0]  parse_phase = PH_HUNT;
	logic [3:0]  frame_pos = '0;
	logic [7:0]  frame_sum = '0;
	logic [1:0]  frame_code = '0;
	logic [7:0]  body_bytes [0:7];
	logic [31:0] hdr_time = '0;
	logic [31:0] accel_time = '0;
	logic        have_accel = 1'b0;
	logic [15:0] sensor_store [0:9] = '{default: 16'h0000};
	logic [31:0] records_predicted = '0;

	imu_record_t pending_records[$];
	imu_record_t typed_records[$];

	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   bytes_sent = 0;
	logic no_gaps = 1'b0;

	string value_names [0:9] = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y",
		"rate_z", "roll_angle", "pitch_angle", "yaw_angle", "temp_raw"};
	logic [15:0] word_extremes [0:3] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};

	frame_row_t directed_rows [0:9] = '{
		'{KIND_ANGLE, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF}, 8'h00, 32'h0000_0000,
			1'b0, '0},
		'{KIND_ACCEL, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, 8'h00, 32'hFFFF_FFFF,
			1'b0, '0},
		'{KIND_RATE, {16'h1111, 16'h2222, 16'h3333, 16'h4444}, 8'h01, 32'h0000_0005,
			1'b0, '0},
		'{8'h50, {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 8'h00, 32'h0000_0007,
			1'b0, '0},
		'{HDR_BYTE, {16'h0051, 16'h0000, 16'h0000, 16'h0000}, 8'h00, 32'h0000_0009,
			1'b0, '0},
		'{8'h54, {16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, 8'h00, 32'h0000_000B,
			1'b0, '0},
		'{KIND_RATE, {16'h8000, 16'h7FFF, 16'h0000, 16'h1234}, 8'h00, 32'h0000_0001,
			1'b0, '0},
		'{KIND_ANGLE, {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000}, 8'h00, 32'h8000_0000,
			1'b1, {32'd0, 32'hFFFF_FFFF, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000,
			16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000}}},
		'{KIND_ACCEL, {16'h0102, 16'h0304, 16'h0506, 16'h0708}, 8'h80, 32'h1234_5678,
			1'b0, '0},
		'{KIND_ANGLE, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 8'h00, 32'h0000_0000,
			1'b1, {32'd1, 32'hFFFF_FFFF, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000,
			16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}}}
	};

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < MAX_PRINTED) begin
			$display("MISMATCH cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		end
		mismatch_count++;
	endtask

	function automatic void advance_parser(input logic [7:0] b, input logic [31:0] stamp);
		imu_record_t rec;
		int base;
		case (parse_phase)
			PH_HUNT: begin
				frame_pos = '0;
				if (b == HDR_BYTE) begin
					hdr_time = stamp;
					frame_sum = b;
					frame_pos = 4'd1;
					parse_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				if (b == KIND_ACCEL || b == KIND_RATE || b == KIND_ANGLE) begin
					frame_code = b[1:0];
					frame_sum = frame_sum + b;
					frame_pos = BODY_START;
					parse_phase = PH_BODY;
				end else begin
					frame_pos = '0;
					parse_phase = PH_HUNT;
				end
			end
			PH_BODY: begin
				if (frame_pos < FRAME_LEN - 4'd1) begin
					body_bytes[3'(frame_pos - BODY_START)] = b;
					frame_sum = frame_sum + b;
					frame_pos = frame_pos + 4'd1;
				end else begin
					if (b == frame_sum) begin
						base = (frame_code == KIND_ACCEL_CODE) ? 0 :
							(frame_code == KIND_RATE_CODE) ? 3 :
							(frame_code == KIND_ANGLE_CODE) ? 6 : -1;
						if (base >= 0) begin
							for (int k = 0; k < 3; k++) begin
								sensor_store[base + k] = {body_bytes[2 * k + 1], body_bytes[2 * k]};
							end
							sensor_store[9] = {body_bytes[7], body_bytes[6]};
						end
						if (frame_code == KIND_ACCEL_CODE) begin
							accel_time = hdr_time;
							have_accel = 1'b1;
						end else if (frame_code == KIND_ANGLE_CODE && have_accel) begin
							rec.seq_no = records_predicted;
							rec.stamp = accel_time;
							for (int k = 0; k < 10; k++) begin
								rec.vals[k] = sensor_store[k];
							end
							if (typed_records.size() > 0) begin
								pending_records.push_back(typed_records.pop_front());
							end else begin
								pending_records.push_back(rec);
							end
							records_predicted = records_predicted + 32'd1;
						end
					end
					frame_pos = '0;
					parse_phase = PH_HUNT;
				end
			end
			default: begin
				frame_pos = '0;
				parse_phase = PH_HUNT;
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [31:0] stamp);
		int gap;
		int r;
		gap = 0;
		if (!no_gaps) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				gap = $urandom_range(1, 3);
			end else if (r < 29) begin
				gap = $urandom_range(10, 40);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		now_stamp <= stamp;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_frame(input frame_row_t row, input int length);
		logic [7:0] frame_bytes [0:10];
		logic [7:0] sum;
		frame_bytes[0] = HDR_BYTE;
		frame_bytes[1] = row.kind_byte;
		for (int k = 0; k < 4; k++) begin
			frame_bytes[2 + 2 * k] = row.words[k][7:0];
			frame_bytes[3 + 2 * k] = row.words[k][15:8];
		end
		sum = '0;
		for (int i = 0; i < 10; i++) begin
			sum = sum + frame_bytes[i];
		end
		frame_bytes[10] = sum + row.sum_skew;
		for (int i = 0; i < length; i++) begin
			send_byte(frame_bytes[i], (i == 0) ? row.hdr_stamp : 32'($urandom));
			if (i == 0 && row.has_typed) begin
				typed_records.push_back(row.typed);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			advance_parser(rx_byte, now_stamp);
		end
	end

	always @(posedge clk) begin : record_check
		imu_record_t got;
		imu_record_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {sequence_res, record_stamp, accel_x, accel_y, accel_z, rate_x, rate_y,
				rate_z, roll_angle, pitch_angle, yaw_angle, temp_raw};
			if (pending_records.size() == 0) begin
				report_mismatch("unexpected record, sequence_res", got.seq_no, 32'h0);
			end else begin
				want = pending_records.pop_front();
				if (got.seq_no !== want.seq_no) begin
					report_mismatch("sequence_res", got.seq_no, want.seq_no);
				end
				if (got.stamp !== want.stamp) begin
					report_mismatch("record_stamp", got.stamp, want.stamp);
				end
				for (int k = 0; k < 10; k++) begin
					if (got.vals[k] !== want.vals[k]) begin
						report_mismatch(value_names[k], 32'(got.vals[k]), 32'(want.vals[k]));
					end
				end
			end
		end
	end

	initial begin : ready_pattern
		int r;
		int run;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				out_ready <= 1'b1;
				run = $urandom_range(50, 200);
			end else if (r < 55) begin
				out_ready <= 1'b1;
				run = $urandom_range(1, 8);
			end else if (r < 92) begin
				out_ready <= 1'b0;
				run = $urandom_range(1, 3);
			end else begin
				out_ready <= 1'b0;
				run = $urandom_range(10, 60);
			end
			repeat (run) @(posedge clk);
		end
	end

	initial begin : stimulus
		frame_row_t row;
		int random_start;
		int r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		now_stamp = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < 10; i++) begin
			send_frame(directed_rows[i], 11);
		end

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			no_gaps = ($urandom_range(0, 99) < 25);
			if ($urandom_range(0, 99) < 30) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 32'($urandom));
			end
			r = $urandom_range(0, 99);
			row.kind_byte = (r < 30) ? KIND_ACCEL : (r < 55) ? KIND_RATE :
				(r < 93) ? KIND_ANGLE : 8'($urandom);
			for (int k = 0; k < 4; k++) begin
				row.words[k] = ($urandom_range(0, 99) < 15) ?
					word_extremes[$urandom_range(0, 3)] : 16'($urandom);
			end
			row.sum_skew = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00;
			if ($urandom_range(0, 99) < 10) begin
				row.hdr_stamp = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
			end else begin
				row.hdr_stamp = 32'($urandom);
			end
			row.has_typed = 1'b0;
			row.typed = '0;
			send_frame(row, ($urandom_range(0, 99) < 5) ? $urandom_range(1, 10) : 11);
		end
		in_valid <= 1'b0;

		do @(posedge clk); while (pending_records.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (typed_records.size() != 0) begin
			report_mismatch("directed record never produced, count", typed_records.size(), 0);
		end
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
